// ===== rtl/core/sga_pkg.sv =====
// ----------------------------------------------------------------------------
// sga_pkg: shared types and constants of the segment glow accumulator
// Command record, register set, segment geometry and fixed-point constants.
// ----------------------------------------------------------------------------
package sga_pkg;

  localparam int DEF_SEGMENT_COUNT = 1024;
  localparam int DEF_MODULE_ROWS   = 8;

  localparam int QUEUE_DEPTH = 2;

  // module pitch and segment offsets, quarter pixels
  localparam int MOD_PITCH_X = 30;
  localparam int MOD_PITCH_Y = 56;
  localparam logic [5:0] SEG_OFF_X [8] = '{6'd15, 6'd6, 6'd24, 6'd15, 6'd24, 6'd6, 6'd25, 6'd15};
  localparam logic [5:0] SEG_OFF_Y [8] = '{6'd10, 6'd19, 6'd19, 6'd28, 6'd37, 6'd37, 6'd51, 6'd46};

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  // ceil(2^21 / 3): exact floor(y / 3) for y below 2^19
  localparam logic [19:0] RECIP3 = 20'd699051;

  localparam logic [15:0] DEF_INV_GAIN  = 16'd3277;
  localparam logic [15:0] DEF_INV2_GAIN = 16'd3277;
  localparam logic [15:0] DEF_GAIN      = 16'd16384;
  localparam logic [7:0]  DEF_CUTOFF    = 8'd50;

  typedef enum logic [1:0] {
    FN_CLEAR = 2'd0,
    FN_ACC   = 2'd1,
    FN_READ  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    CFG_INV_GAIN  = 2'd0,
    CFG_INV2_GAIN = 2'd1,
    CFG_GAIN      = 2'd2,
    CFG_CUTOFF    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    func_t       func;
    logic [11:0] qx;   // quarter pixels
    logic [11:0] qy;
    logic [17:0] rgb;  // red + green + blue
    logic [9:0]  pos;
  } cmd_t;

  typedef struct packed {
    logic [15:0] inv_gain;
    logic [15:0] inv2_gain;
    logic [15:0] gain;
    logic [7:0]  cutoff;
  } cfg_t;

endpackage

// ===== rtl/core/sga_ram.sv =====
// ----------------------------------------------------------------------------
// sga_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sga_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/sga_front.sv =====
// ----------------------------------------------------------------------------
// sga_front: request intake, register file and command queue
// Takes requests, drops unused codes, queues command records for the back.
// ----------------------------------------------------------------------------
module sga_front
  import sga_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [9:0]  in_pixel_x,
  input  logic [9:0]  in_pixel_y,
  input  logic [15:0] in_red,
  input  logic [15:0] in_green,
  input  logic [15:0] in_blue,
  input  logic [9:0]  in_out_position,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  cfg_t       cfg_r;
  cmd_t       q_r [QUEUE_DEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       known, push;
  cmd_t       new_cmd;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;
  assign busy      = (cnt_r == 2'(QUEUE_DEPTH));

  assign known = (in_func == FN_CLEAR) || (in_func == FN_ACC) || (in_func == FN_READ);
  assign push  = start && !busy && known;

  always_comb begin
    new_cmd.func = func_t'(in_func);
    new_cmd.qx   = {in_pixel_x, 2'b00};
    new_cmd.qy   = {in_pixel_y, 2'b00};
    new_cmd.rgb  = 18'(in_red) + 18'(in_green) + 18'(in_blue);
    new_cmd.pos  = in_out_position;
  end

  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_gain  <= DEF_INV_GAIN;
      cfg_r.inv2_gain <= DEF_INV2_GAIN;
      cfg_r.gain      <= DEF_GAIN;
      cfg_r.cutoff    <= DEF_CUTOFF;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_INV_GAIN:  cfg_r.inv_gain  <= cfg_data;
          CFG_INV2_GAIN: cfg_r.inv2_gain <= cfg_data;
          CFG_GAIN:      cfg_r.gain      <= cfg_data;
          CFG_CUTOFF:    cfg_r.cutoff    <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (push) begin
        q_r[wp_r] <= new_cmd;
        wp_r      <= ~wp_r;
      end
      if (cmd_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(cmd_pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(QUEUE_DEPTH)) else $error("queue overfilled");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cnt_r != 2'd0) else $error("pop from empty queue");

endmodule

// ===== rtl/core/sga_back.sv =====
// ----------------------------------------------------------------------------
// sga_back: command execution sequencer
// Clear sweep, per-segment glow update with iterative root and divide, reads.
// ----------------------------------------------------------------------------
module sga_back
  import sga_pkg::*;
#(
  parameter int SEGMENT_COUNT = DEF_SEGMENT_COUNT,
  parameter int MODULE_ROWS   = DEF_MODULE_ROWS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  input  cfg_t       cfg,
  output logic       out_valid,
  output logic [7:0] out_level
);

  localparam int IDX_W  = $clog2(SEGMENT_COUNT);
  localparam int ROW_W  = (MODULE_ROWS > 1) ? $clog2(MODULE_ROWS) : 1;
  localparam int COLS   = (SEGMENT_COUNT / 8 + MODULE_ROWS - 1) / MODULE_ROWS;
  localparam int MAXC   = COLS * MOD_PITCH_X + MODULE_ROWS * MOD_PITCH_Y + 4096;
  localparam int C_W    = $clog2(MAXC);
  localparam int D2F_W  = 2 * C_W + 1;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_GEO, ST_SQX, ST_SQY, ST_CHK, ST_SQRT, ST_DIV1,
    ST_DIV2, ST_GAIN, ST_SCL1, ST_SCL2, ST_UPD, ST_RD1, ST_RD2
  } state_t;

  state_t             state_r;
  logic [IDX_W-1:0]   idx_r;
  logic [ROW_W-1:0]   row_r;
  logic [C_W-1:0]     sxb_r, syb_r, qx_r, qy_r, dx_r, dy_r;
  logic [17:0]        rgb_r;
  logic [9:0]         pos_r;
  logic [D2F_W-1:0]   d2_r;
  logic [35:0]        sq_n_r;
  logic [19:0]        sq_rem_r;
  logic [17:0]        sq_root_r;
  logic [4:0]         cnt_r;
  logic [27:0]        dv_num_r;
  logic [19:0]        dv_rem_r, dv_den_r, t1_r;
  logic [16:0]        f_r, c_r;
  logic [17:0]        y_r;
  logic               out_valid_r;
  logic [7:0]         out_level_r;

  logic [C_W-1:0]     sx, sy, dx, dy;
  logic [19:0]        lim2;
  logic [21:0]        sq_acc, sq_trial;
  logic [19:0]        sq_rem_nxt;
  logic [17:0]        sq_root_nxt;
  logic [20:0]        dv_acc;
  logic               dv_ge;
  logic [19:0]        dv_rem_nxt;
  logic [27:0]        dv_num_nxt;
  logic [22:0]        fsum;
  logic [38:0]        gprod;
  logic [24:0]        fq;
  logic               in_range, last_seg;
  logic [IDX_W-1:0]   rd_addr;
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [16:0]        ram_wdata, ram_rdata;

  // segment geometry
  assign sx = sxb_r + C_W'(SEG_OFF_X[idx_r[2:0]]);
  assign sy = syb_r + C_W'(SEG_OFF_Y[idx_r[2:0]]);
  assign dx = (sx >= qx_r) ? (sx - qx_r) : (qx_r - sx);
  assign dy = (sy >= qy_r) ? (sy - qy_r) : (qy_r - sy);
  assign lim2 = 20'({cfg.cutoff, 2'b00}) * 20'({cfg.cutoff, 2'b00});

  // one root digit a step
  assign sq_acc   = {sq_rem_r, sq_n_r[35:34]};
  assign sq_trial = {2'b00, sq_root_r, 2'b01};
  always_comb begin
    if (sq_acc >= sq_trial) begin
      sq_rem_nxt  = 20'(sq_acc - sq_trial);
      sq_root_nxt = {sq_root_r[16:0], 1'b1};
    end else begin
      sq_rem_nxt  = sq_acc[19:0];
      sq_root_nxt = {sq_root_r[16:0], 1'b0};
    end
  end

  // one quotient bit a step
  assign dv_acc     = {dv_rem_r, dv_num_r[27]};
  assign dv_ge      = (dv_acc >= {1'b0, dv_den_r});
  assign dv_rem_nxt = dv_ge ? 20'(dv_acc - {1'b0, dv_den_r}) : dv_acc[19:0];
  assign dv_num_nxt = {dv_num_r[26:0], dv_ge};

  assign fsum  = 23'(t1_r) + dv_num_r[22:0];
  assign gprod = 39'(cfg.gain) * 39'(fsum);
  assign fq    = gprod[38:14];

  assign in_range = ({22'd0, pos_r} < 32'(SEGMENT_COUNT));
  assign rd_addr  = IDX_W'(SEGMENT_COUNT - 1) - IDX_W'(pos_r);
  assign last_seg = (idx_r == IDX_W'(SEGMENT_COUNT - 1));

  assign cmd_pop   = (state_r == ST_IDLE) && cmd_valid;
  assign ram_re    = (state_r == ST_GEO) || (state_r == ST_RD1 && in_range);
  assign ram_raddr = (state_r == ST_RD1) ? rd_addr : idx_r;
  assign ram_we    = (state_r == ST_CLR) || (state_r == ST_UPD && c_r > ram_rdata);
  assign ram_wdata = (state_r == ST_CLR) ? 17'd0 : c_r;

  sga_ram #(.WIDTH(17), .DEPTH(SEGMENT_COUNT)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_RD2);
      case (state_r)
        ST_CLR: begin
          idx_r <= idx_r + 1'b1;
          if (last_seg) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_valid) begin
            qx_r  <= C_W'(cmd.qx);
            qy_r  <= C_W'(cmd.qy);
            rgb_r <= cmd.rgb;
            pos_r <= cmd.pos;
            idx_r <= '0;
            row_r <= '0;
            sxb_r <= '0;
            syb_r <= '0;
            case (cmd.func)
              FN_CLEAR: state_r <= ST_CLR;
              FN_ACC:   state_r <= ST_GEO;
              FN_READ:  state_r <= ST_RD1;
              default:  state_r <= ST_IDLE;
            endcase
          end
        end
        ST_GEO: begin
          dx_r    <= dx;
          dy_r    <= dy;
          state_r <= ST_SQX;
        end
        ST_SQX: begin
          d2_r    <= D2F_W'(dx_r) * D2F_W'(dx_r);
          state_r <= ST_SQY;
        end
        ST_SQY: begin
          d2_r    <= d2_r + D2F_W'(dy_r) * D2F_W'(dy_r);
          state_r <= ST_CHK;
        end
        ST_CHK: begin
          sq_n_r    <= {d2_r[19:0], 16'd0};
          sq_rem_r  <= '0;
          sq_root_r <= '0;
          cnt_r     <= '0;
          f_r       <= ONE_Q16;
          if (d2_r > D2F_W'(lim2)) begin
            state_r <= ST_UPD;
            c_r     <= '0;       // never above stored value: no write
          end else if (d2_r == '0) begin
            state_r <= ST_SCL1;
          end else begin
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          sq_n_r    <= {sq_n_r[33:0], 2'b00};
          sq_rem_r  <= sq_rem_nxt;
          sq_root_r <= sq_root_nxt;
          if (cnt_r == 5'd17) begin
            dv_num_r <= {cfg.inv_gain, 12'd0};
            dv_rem_r <= '0;
            dv_den_r <= 20'(sq_root_nxt);
            cnt_r    <= '0;
            state_r  <= ST_DIV1;
          end else begin
            cnt_r    <= cnt_r + 1'b1;
          end
        end
        ST_DIV1: begin
          if (cnt_r == 5'd27) begin
            t1_r     <= dv_num_nxt[19:0];
            dv_num_r <= {6'd0, cfg.inv2_gain, 6'd0};
            dv_rem_r <= '0;
            dv_den_r <= d2_r[19:0];
            cnt_r    <= '0;
            state_r  <= ST_DIV2;
          end else begin
            dv_num_r <= dv_num_nxt;
            dv_rem_r <= dv_rem_nxt;
            cnt_r    <= cnt_r + 1'b1;
          end
        end
        ST_DIV2: begin
          dv_num_r <= dv_num_nxt;
          dv_rem_r <= dv_rem_nxt;
          cnt_r    <= cnt_r + 1'b1;
          if (cnt_r == 5'd27) begin
            state_r <= ST_GAIN;
          end
        end
        ST_GAIN: begin
          f_r     <= (fq > 25'(ONE_Q16)) ? ONE_Q16 : fq[16:0];
          state_r <= ST_SCL1;
        end
        ST_SCL1: begin
          y_r     <= 18'((35'(f_r) * 35'(rgb_r)) >> 16);
          state_r <= ST_SCL2;
        end
        ST_SCL2: begin
          c_r     <= 17'((38'(y_r) * 38'(RECIP3)) >> 21);
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          if (last_seg) begin
            state_r <= ST_IDLE;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= ST_GEO;
            if (idx_r[2:0] == 3'd7) begin
              if (row_r == ROW_W'(MODULE_ROWS - 1)) begin
                row_r <= '0;
                syb_r <= '0;
                sxb_r <= sxb_r + C_W'(MOD_PITCH_X);
              end else begin
                row_r <= row_r + 1'b1;
                syb_r <= syb_r + C_W'(MOD_PITCH_Y);
              end
            end
          end
        end
        ST_RD1: begin
          state_r <= ST_RD2;
        end
        ST_RD2: begin
          out_level_r <= in_range ? 8'((25'(ram_rdata) * 25'd255) >> 16) : 8'd0;
          state_r     <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_level = out_level_r;

  a_out_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_RD2)) else $error("result without read");
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLR || state_r == ST_UPD)) else $error("stray store write");
  a_falloff_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCL1 |-> f_r <= ONE_Q16) else $error("falloff above one");

endmodule

// ===== rtl/core/segment_glow_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// segment_glow_accumulator_top: seven-segment glow accumulator
// Keeps a per-segment brightness store fed by pixels, with clear and read.
// ----------------------------------------------------------------------------
// Requests are taken when start is high and busy is low; a two-deep queue
// sits between the intake and the sequencer, so busy only rises when two
// requests are waiting. Results cannot be stalled: a read request gives one
// out_valid pulse with out_level, registered after the sequencer picks it
// up and passes ST_RD1 and ST_RD2. After reset the store is swept to zero
// before the first request is executed (requests still queue); a clear
// sweeps it to zero the same way. A pixel walks every segment one after
// another: a segment beyond the cutoff passes ST_GEO, ST_SQX, ST_SQY,
// ST_CHK and ST_UPD, one at zero distance adds ST_SCL1 and ST_SCL2, any
// other also runs ST_GAIN and the 18-step square root and two 28-step
// dividers, one digit per cycle; a pixel's cost depends on how many segments fall inside the cutoff.
// Register writes take effect at once (cfg_ready is always high) and must
// only be made while the block is idle.
// ----------------------------------------------------------------------------
module segment_glow_accumulator_top
  import sga_pkg::*;
#(
  parameter int SEGMENT_COUNT = DEF_SEGMENT_COUNT,
  parameter int MODULE_ROWS   = DEF_MODULE_ROWS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [9:0]  in_pixel_x,
  input  logic [9:0]  in_pixel_y,
  input  logic [15:0] in_red,
  input  logic [15:0] in_green,
  input  logic [15:0] in_blue,
  input  logic [9:0]  in_out_position,
  output logic        out_valid,
  output logic [7:0]  out_level,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg;
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  // intake: registers, decode, request queue
  sga_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_out_position (in_out_position),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cfg             (cfg),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop)
  );

  // execution: store sweep, glow update, read-out
  sga_back #(
    .SEGMENT_COUNT (SEGMENT_COUNT),
    .MODULE_ROWS   (MODULE_ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_level (out_level)
  );

endmodule

// ===== tb/sv/segment_glow_accumulator_check.sv =====
// ----------------------------------------------------------------------------
// segment_glow_accumulator_check: result checker for the glow accumulator
// Watches the request, register and result channels, keeps its own copy of
// the segment store and compares every read result with its prediction.
// ----------------------------------------------------------------------------
module segment_glow_accumulator_check
  import sga_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_func,
  input  logic [9:0]  in_pixel_x,
  input  logic [9:0]  in_pixel_y,
  input  logic [15:0] in_red,
  input  logic [15:0] in_green,
  input  logic [15:0] in_blue,
  input  logic [9:0]  in_out_position,
  input  logic        out_valid,
  input  logic [7:0]  out_level,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          reads_checked
);

  localparam int SEGS = 1024;
  localparam int ROWS = 8;

  // segment offsets inside a module, quarter pixels
  localparam int OFF_X [8] = '{15, 6, 24, 15, 24, 6, 25, 15};
  localparam int OFF_Y [8] = '{10, 19, 19, 28, 37, 37, 51, 46};

  logic [16:0] glow [SEGS];
  logic [15:0] k1, k2, gain;
  logic [7:0]  cutoff;
  logic [7:0]  level_q[$];

  assign pending = level_q.size();

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %0t: %s got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic longint unsigned root64(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic glow_pixel(input int px, input int py, input longint unsigned sum);
    longint unsigned dx, dy, d2, lim2, s, f, c;
    int sx, sy, m;
    lim2 = (longint'(cutoff) * 4) * (longint'(cutoff) * 4);
    for (int i = 0; i < SEGS; i++) begin
      m  = i >> 3;
      sx = (m / ROWS) * 30 + OFF_X[i & 7];
      sy = (m % ROWS) * 56 + OFF_Y[i & 7];
      dx = (sx >= px * 4) ? sx - px * 4 : px * 4 - sx;
      dy = (sy >= py * 4) ? sy - py * 4 : py * 4 - sy;
      d2 = dx * dx + dy * dy;
      if (d2 > lim2) continue;
      if (d2 == 0) begin
        f = 65536;
      end else begin
        s = root64(d2 << 16);
        f = (longint'(gain) * ((longint'(k1) * 4096) / s + (longint'(k2) * 64) / d2)) >> 14;
        if (f > 65536) f = 65536;
      end
      c = (f * sum) / 196608;
      if (c > glow[i]) glow[i] = c[16:0];
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (glow[i]) glow[i] = '0;
      k1 = DEF_INV_GAIN;
      k2 = DEF_INV2_GAIN;
      gain = DEF_GAIN;
      cutoff = DEF_CUTOFF;
      level_q.delete();
      fail_count = 0;
      reads_checked = 0;
    end else begin
      if (out_valid) begin
        if (level_q.size() == 0) begin
          report("unexpected result level", out_level, -1);
        end else begin
          if (out_level !== level_q[0]) report("level", out_level, level_q[0]);
          void'(level_q.pop_front());
          reads_checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_INV_GAIN:  k1 = cfg_data;
          CFG_INV2_GAIN: k2 = cfg_data;
          CFG_GAIN:      gain = cfg_data;
          CFG_CUTOFF:    cutoff = cfg_data[7:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (in_func)
          FN_CLEAR: foreach (glow[i]) glow[i] = '0;
          FN_ACC:   glow_pixel(int'(in_pixel_x), int'(in_pixel_y),
                               longint'(in_red) + in_green + in_blue);
          FN_READ:  level_q.push_back(8'((longint'(glow[SEGS - 1 - in_out_position]) * 255) >> 16));
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/sv/segment_glow_accumulator_top_test.sv =====
// ----------------------------------------------------------------------------
// segment_glow_accumulator_top_test: testbench for the glow accumulator
// Drives clear, pixel, read and unused requests with random gaps across
// several register settings; a side checker predicts and compares reads.
// ----------------------------------------------------------------------------
module segment_glow_accumulator_top_test;
  import sga_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_func = FN_CLEAR;
  logic [9:0]  in_pixel_x = '0;
  logic [9:0]  in_pixel_y = '0;
  logic [15:0] in_red = '0;
  logic [15:0] in_green = '0;
  logic [15:0] in_blue = '0;
  logic [9:0]  in_out_position = '0;
  logic        out_valid;
  logic [7:0]  out_level;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_INV_GAIN;
  logic [15:0] cfg_data = '0;
  int          fail_count, pending, reads_checked;
  int          n_req, n_pix;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  segment_glow_accumulator_top DUT (.*);

  segment_glow_accumulator_check checker_i (.*);

  // mostly short pauses, now and then a long one
  task automatic pause();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // one request; called at a rising edge, waits for the edge that takes it, then pauses
  task automatic send(input func_t f, input int px, input int py,
                      input int r, input int g, input int b, input int pos);
    start <= 1'b1;
    in_func <= f;
    in_pixel_x <= 10'(px);
    in_pixel_y <= 10'(py);
    in_red <= 16'(r);
    in_green <= 16'(g);
    in_blue <= 16'(b);
    in_out_position <= 10'(pos);
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    n_req++;
    if (f == FN_ACC) n_pix++;
    pause();
  endtask

  task automatic read_at(input int pos);
    send(FN_READ, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 65535),
         $urandom_range(0, 65535), $urandom_range(0, 65535), pos);
  endtask

  // a read follows all earlier requests, so its result marks the block idle
  task automatic drain();
    read_at($urandom_range(0, 1023));
    start <= 1'b0;
    // let the checker log the read before looking at its queue
    @(negedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 16'(value);
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_request();
    int sel, px, py;
    sel = $urandom_range(0, 99);
    // most pixels land on the display area so segments light up
    if ($urandom_range(0, 4) != 0) begin
      px = $urandom_range(0, 125);
      py = $urandom_range(0, 115);
    end else begin
      px = $urandom_range(0, 1023);
      py = $urandom_range(0, 1023);
    end
    if (sel < 4)
      send(FN_CLEAR, px, py, $urandom_range(0, 65535), $urandom_range(0, 65535),
           $urandom_range(0, 65535), $urandom_range(0, 1023));
    else if (sel < 40)
      send(FN_ACC, px, py, $urandom_range(0, 65535), $urandom_range(0, 65535),
           $urandom_range(0, 65535), $urandom_range(0, 1023));
    else if (sel < 95)
      read_at($urandom_range(0, 1023));
    else
      send(func_t'(2'd3), px, py, $urandom_range(0, 65535), $urandom_range(0, 65535),
           $urandom_range(0, 65535), $urandom_range(0, 1023));
  endtask

  initial begin
    n_req = 0;
    n_pix = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset register values
    read_at(0);
    read_at(1023);
    send(FN_ACC, 6, 7, 65535, 65535, 65535, 0);       // full white next to a segment
    send(FN_ACC, 15, 14, 0, 0, 0, 0);                 // black pixel leaves the store
    send(FN_ACC, 0, 0, 1, 0, 0, 1023);
    send(FN_ACC, 1023, 1023, 65535, 65535, 65535, 0); // far corner, nothing in reach
    read_at(1023);
    read_at(1022);
    read_at(1021);
    read_at(1020);
    send(func_t'(2'd3), 6, 7, 65535, 65535, 65535, 1023); // unused code, ignored
    read_at(1016);
    send(FN_CLEAR, 0, 0, 0, 0, 0, 0);
    read_at(1021);
    read_at(512);
    drain();

    // cutoff at both extremes, gains at both extremes
    write_reg(CFG_CUTOFF, 255);
    write_reg(CFG_GAIN, 65535);
    write_reg(CFG_INV_GAIN, 65535);
    write_reg(CFG_INV2_GAIN, 0);
    send(FN_ACC, 60, 56, 40000, 50000, 60000, 0);     // reaches every segment
    send(FN_ACC, 1023, 1023, 65535, 65535, 65535, 0);
    read_at(0);
    read_at(511);
    read_at(1023);
    drain();
    write_reg(CFG_CUTOFF, 0);
    write_reg(CFG_GAIN, 0);
    send(FN_ACC, 6, 7, 65535, 65535, 65535, 0);
    read_at(1021);
    drain();

    // random phases, each with its own register setting
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_INV_GAIN, ph == 0 ? 0 : $urandom_range(0, 65535));
      write_reg(CFG_INV2_GAIN, ph == 1 ? 65535 : $urandom_range(0, 65535));
      write_reg(CFG_GAIN, ph == 2 ? 65535 : $urandom_range(0, 40000));
      // small reach keeps most segments of each pixel beyond the cutoff
      write_reg(CFG_CUTOFF, $urandom_range(0, 6));
      if (ph == 3) send(FN_CLEAR, 0, 0, 0, 0, 0, 0);
      repeat (105) random_request();
      drain();
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("%0d requests sent, %0d of them pixels, %0d read results checked",
             n_req, n_pix, reads_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("timeout with %0d results outstanding", pending);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
